>>> sv/s2l_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and ROM tables for the solar-to-lunar date converter.
// No dependencies; every other file imports this package.
package s2l_pkg;

   localparam int TABLE_YEARS = 12;

   localparam logic [4:0] NO_TERM     = 5'd24;
   localparam logic [4:0] HALF_SPLIT  = 5'd15;
   localparam logic [5:0] LATE_BIAS   = 6'd15;
   localparam logic [4:0] DAYS_LONG   = 5'd30;
   localparam logic [4:0] DAYS_SHORT  = 5'd29;
   localparam logic [3:0] MONTH_LAST  = 4'd11;
   localparam logic [3:0] WALK_LAST   = 4'd12;
   localparam logic [9:0] YEAR_DAYS   = 10'd365;

   typedef struct packed {
      logic [10:0] greg_year;
      logic [3:0]  month_index;
      logic [4:0]  day_in_month;
      logic [8:0]  day_in_year;
   } req_type;

   typedef struct packed {
      logic [3:0] lunar_month;
      logic [4:0] lunar_day;
      logic       is_leap_month;
      logic [4:0] solar_term;
      logic       out_of_range;
   } rsp_type;

   typedef struct packed {
      logic [12:0] month_len;
      logic [3:0]  leap_month;
      logic [5:0]  new_year_day;
   } year_rec_type;

   typedef struct packed {
      logic         go;
      year_rec_type rec;
      logic [9:0]   days;
   } walk_cmd_type;

   typedef struct packed {
      logic       done;
      logic       bad;
      logic [3:0] month;
      logic [4:0] day;
      logic       leap;
   } walk_res_type;

   function automatic year_rec_type year_rec(input logic [3:0] idx);
      logic [23:0] raw;
      begin
         case (idx)
            4'd0:    raw = 24'h56c895;
            4'd1:    raw = 24'h1b4828;
            4'd2:    raw = 24'h3a959c;
            4'd3:    raw = 24'h1c942f;
            4'd4:    raw = 24'h192c24;
            4'd5:    raw = 24'h325d59;
            4'd6:    raw = 24'h32ac2b;
            4'd7:    raw = 24'h156821;
            4'd8:    raw = 24'h2b58d6;
            4'd9:    raw = 24'h2da429;
            4'd10:   raw = 24'h5d4ade;
            4'd11:   raw = 24'h2d4831;
            default: raw = 24'h000000;
         endcase
         return year_rec_type'(raw[22:0]);
      end
   endfunction

   function automatic logic [23:0] term_bits(input logic [3:0] idx);
      begin
         case (idx)
            4'd0:                 return 24'hdbfffc;
            4'd4, 4'd8:           return 24'hc3fffc;
            4'd1, 4'd5, 4'd9:     return 24'h00080d;
            4'd2, 4'd6, 4'd10:    return 24'h429a80;
            4'd3, 4'd7, 4'd11:    return 24'hc2bac4;
            default:              return 24'h000000;
         endcase
      end
   endfunction

   function automatic logic [7:0] term_base(input logic [3:0] mon);
      begin
         case (mon)
            4'd0, 4'd2, 4'd4, 4'd5: return 8'h55;
            4'd1:                   return 8'h33;
            4'd3:                   return 8'h44;
            4'd6, 4'd10:            return 8'h76 | {7'd0, mon == 4'd10};
            4'd7, 4'd8:             return 8'h77;
            4'd9:                   return 8'h88;
            4'd11:                  return 8'h66;
            default:                return 8'h00;
         endcase
      end
   endfunction

endpackage

>>> sv/s2l_term.sv
`timescale 1ns / 1ps
// Solar term lookup: checks whether the given Gregorian day is a term day.
// Depends on s2l_pkg for the term tables.
module s2l_term import s2l_pkg::*; (
   input  logic [3:0] year_idx,
   input  logic [3:0] month_index,
   input  logic [4:0] day_in_month,
   output logic [4:0] solar_term
);

   logic        half;
   logic [7:0]  base;
   logic [23:0] bits;
   logic [4:0]  bit_idx;
   logic        term_bit;
   logic [5:0]  target;

   always_comb begin
      half     = day_in_month > HALF_SPLIT;
      base     = term_base(month_index);
      bits     = term_bits(year_idx);
      // each month owns two bits: early term, then late term
      bit_idx  = {month_index, half};
      term_bit = (month_index > MONTH_LAST) ? 1'b0 : bits[bit_idx];
      target   = {5'd0, term_bit} +
                 (half ? ({2'b00, base[7:4]} + LATE_BIAS) : {2'b00, base[3:0]});
      if (month_index > MONTH_LAST || {1'b0, day_in_month} != target)
         solar_term = NO_TERM;
      else
         solar_term = {month_index, half};
   end

endmodule

>>> sv/s2l_walk.sv
`timescale 1ns / 1ps
// Lunar month walker: one subtract/compare per cycle over the month-length bits,
// then the intercalary month correction. Depends on s2l_pkg.
module s2l_walk import s2l_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  walk_cmd_type cmd,
   output walk_res_type res
);

   typedef enum logic [1:0] {W_IDLE, W_RUN, W_FIX} state_type;

   state_type    state_ff;
   year_rec_type rec_ff;
   logic [9:0]   days_ff;
   logic [3:0]   mon_ff;
   logic         done_ff;
   logic         bad_ff;
   logic [3:0]   month_ff;
   logic [4:0]   day_ff;
   logic         leap_ff;

   logic [4:0]   mdays;
   logic         fits;
   logic [9:0]   days_in;
   logic [3:0]   mon_in;
   logic         has_leap;
   logic         leap_hit;
   logic [3:0]   adj_month;

   always_comb begin
      mdays     = rec_ff.month_len[mon_ff] ? DAYS_LONG : DAYS_SHORT;
      fits      = days_ff <= {5'd0, mdays};
      days_in   = days_ff - {5'd0, mdays};
      mon_in    = mon_ff + 4'd1;
      has_leap  = rec_ff.leap_month != 4'd0;
      leap_hit  = has_leap && (rec_ff.leap_month == mon_ff);
      // months from the leap month on count one less
      adj_month = (has_leap && rec_ff.leap_month <= mon_ff) ? mon_ff - 4'd1 : mon_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            W_IDLE: begin
               if (cmd.go) begin
                  rec_ff   <= cmd.rec;
                  days_ff  <= cmd.days;
                  mon_ff   <= 4'd0;
                  state_ff <= W_RUN;
               end
            end
            W_RUN: begin
               if (fits) begin
                  state_ff <= W_FIX;
               end else if (mon_ff == WALK_LAST) begin
                  // ran past the thirteenth month
                  done_ff  <= 1'b1;
                  bad_ff   <= 1'b1;
                  state_ff <= W_IDLE;
               end else begin
                  days_ff <= days_in;
                  mon_ff  <= mon_in;
               end
            end
            W_FIX: begin
               done_ff  <= 1'b1;
               bad_ff   <= adj_month > MONTH_LAST;
               month_ff <= adj_month;
               day_ff   <= days_ff[4:0] - 5'd1;
               leap_ff  <= leap_hit;
               state_ff <= W_IDLE;
            end
            default: state_ff <= W_IDLE;
         endcase
      end
   end

   assign res.done  = done_ff;
   assign res.bad   = bad_ff;
   assign res.month = month_ff;
   assign res.day   = day_ff;
   assign res.leap  = leap_ff;

endmodule

>>> sv/solar_to_lunar_date.sv
`timescale 1ns / 1ps
// Top level of the Gregorian to Chinese lunar date converter.
// Depends on s2l_pkg, s2l_term and s2l_walk.
//
//   channel   ports                   transfer
//   request   start, busy, req_data   start high while busy low
//   response  rsp_strobe, rsp_data    one cycle per transaction, no back-pressure
//
// A transaction with no usable year record is answered from T_LOOK without a month walk.
// Otherwise it goes on to T_WALK, where the month walk skips k = 0..12 months and
// retires one lunar month per cycle through the single subtract/compare unit.
// busy stays high from accept until the response strobe; a new transaction
// may be started in the strobe cycle. Reset clears all control state.
module solar_to_lunar_date import s2l_pkg::*; #(
   parameter int FIRST_YEAR = 2023,
   parameter int NUM_YEARS  = 12
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int YEARS_USED = (NUM_YEARS < TABLE_YEARS) ? NUM_YEARS : TABLE_YEARS;

   typedef enum logic [1:0] {T_IDLE, T_LOOK, T_WALK} state_type;

   state_type    state_ff;
   req_type      req_ff;
   logic [4:0]   term_ff;
   logic         strobe_ff;
   rsp_type      rsp_ff;

   logic [TABLE_YEARS-1:0] prev_leap;
   logic [12:0]  year_diff;
   logic         year_ok;
   logic [3:0]   year_idx;
   logic [3:0]   prev_idx;
   year_rec_type cur_rec;
   year_rec_type prev_rec;
   logic         need_prev;
   logic [9:0]   days_cur;
   logic [9:0]   days_prev;
   logic [4:0]   term_val;
   walk_cmd_type walk_cmd;
   walk_res_type walk_res;

   // leap flag of the Gregorian year before each table year
   for (genvar g = 0; g < TABLE_YEARS; g++) begin : g_leap
      localparam int PY = FIRST_YEAR + g - 1;
      localparam bit IS_LEAP = ((PY % 4 == 0) && (PY % 100 != 0)) || (PY % 400 == 0);
      assign prev_leap[g] = IS_LEAP;
   end

   always_comb begin
      year_diff = {2'b00, req_ff.greg_year} - 13'(FIRST_YEAR);
      year_ok   = !year_diff[12] && (year_diff[11:0] < 12'(YEARS_USED));
      year_idx  = year_diff[3:0];
      prev_idx  = year_idx - 4'd1;
      cur_rec   = year_rec(year_idx);
      prev_rec  = year_rec(prev_idx);
      need_prev = {3'd0, cur_rec.new_year_day} > req_ff.day_in_year;
      days_cur  = {1'b0, req_ff.day_in_year} - {4'd0, cur_rec.new_year_day} + 10'd1;
      days_prev = {1'b0, req_ff.day_in_year} + YEAR_DAYS + {9'd0, prev_leap[year_idx]}
                  - {4'd0, prev_rec.new_year_day} + 10'd1;
   end

   s2l_term u_term (
      .year_idx     (year_idx),
      .month_index  (req_ff.month_index),
      .day_in_month (req_ff.day_in_month),
      .solar_term   (term_val)
   );

   always_comb begin
      walk_cmd.go   = (state_ff == T_LOOK) && year_ok && !(need_prev && year_idx == 4'd0);
      walk_cmd.rec  = need_prev ? prev_rec : cur_rec;
      walk_cmd.days = need_prev ? days_prev : days_cur;
   end

   s2l_walk u_walk (
      .clock (clock),
      .reset (reset),
      .cmd   (walk_cmd),
      .res   (walk_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= T_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         case (state_ff)
            T_IDLE: begin
               if (start) begin
                  req_ff   <= req_data;
                  state_ff <= T_LOOK;
               end
            end
            T_LOOK: begin
               term_ff <= term_val;
               if (walk_cmd.go) begin
                  state_ff <= T_WALK;
               end else begin
                  // no usable record: flag and drop the lunar fields
                  strobe_ff            <= 1'b1;
                  rsp_ff.lunar_month   <= 4'd0;
                  rsp_ff.lunar_day     <= 5'd0;
                  rsp_ff.is_leap_month <= 1'b0;
                  rsp_ff.solar_term    <= year_ok ? term_val : NO_TERM;
                  rsp_ff.out_of_range  <= 1'b1;
                  state_ff             <= T_IDLE;
               end
            end
            T_WALK: begin
               if (walk_res.done) begin
                  strobe_ff            <= 1'b1;
                  rsp_ff.lunar_month   <= walk_res.bad ? 4'd0 : walk_res.month;
                  rsp_ff.lunar_day     <= walk_res.bad ? 5'd0 : walk_res.day;
                  rsp_ff.is_leap_month <= walk_res.bad ? 1'b0 : walk_res.leap;
                  rsp_ff.solar_term    <= term_ff;
                  rsp_ff.out_of_range  <= walk_res.bad;
                  state_ff             <= T_IDLE;
               end
            end
            default: state_ff <= T_IDLE;
         endcase
      end
   end

   assign busy       = state_ff != T_IDLE;
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after a started transaction");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for more than one cycle");

   a_lunar_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.out_of_range |->
         rsp_data.lunar_month <= MONTH_LAST && rsp_data.lunar_day < DAYS_LONG)
      else $error("lunar date out of range on a valid response");

   a_oor_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.out_of_range |->
         rsp_data.lunar_month == 4'd0 && rsp_data.lunar_day == 5'd0 &&
         !rsp_data.is_leap_month)
      else $error("lunar fields not cleared on an out-of-range response");

   a_walk_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      walk_res.done |-> state_ff == T_WALK)
      else $error("month walk finished outside a transaction");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for solar_to_lunar_date: a directed table of dates, then random dates, each response
// checked against the table's expected values or a lunar calendar predictor kept in this file.
// Depends on s2l_pkg and the solar_to_lunar_date RTL.
module testbench;
   import s2l_pkg::*;

   localparam int FIRST_YEAR   = 2023;
   localparam int NUM_YEARS    = 12;
   localparam int RANDOM_DATES = 650;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 20;

   // Lunar year records: [5:0] new year day, [9:6] leap month, [22:10] month lengths.
   localparam logic [23:0] LUNAR_YEAR [NUM_YEARS] = '{
      24'h56c895, 24'h1b4828, 24'h3a959c, 24'h1c942f, 24'h192c24, 24'h325d59,
      24'h32ac2b, 24'h156821, 24'h2b58d6, 24'h2da429, 24'h5d4ade, 24'h2d4831
   };

   localparam logic [7:0] SOLAR_BASE [12] = '{
      8'h55, 8'h33, 8'h55, 8'h44, 8'h55, 8'h55, 8'h76, 8'h77, 8'h77, 8'h88, 8'h77, 8'h66
   };

   localparam logic [7:0] SOLAR_MASK [NUM_YEARS * 3] = '{
      8'hfc, 8'hff, 8'hdb, 8'h0d, 8'h08, 8'h00, 8'h80, 8'h9a, 8'h42, 8'hc4, 8'hba, 8'hc2,
      8'hfc, 8'hff, 8'hc3, 8'h0d, 8'h08, 8'h00, 8'h80, 8'h9a, 8'h42, 8'hc4, 8'hba, 8'hc2,
      8'hfc, 8'hff, 8'hc3, 8'h0d, 8'h08, 8'h00, 8'h80, 8'h9a, 8'h42, 8'hc4, 8'hba, 8'hc2
   };

   localparam rsp_type OUT_OF_TABLE = '{4'd0, 5'd0, 1'b0, NO_TERM, 1'b1};
   localparam rsp_type PREDICTED    = '0;

   typedef struct packed {
      req_type req;
      logic    known;
      rsp_type rsp;
   } date_row_type;

   localparam date_row_type DIRECTED [21] = '{
      '{'{11'd2022, 4'd5, 5'd10, 9'd160}, 1'b1, OUT_OF_TABLE},
      '{'{11'd2035, 4'd0, 5'd1, 9'd0}, 1'b1, OUT_OF_TABLE},
      '{'{11'd0, 4'd0, 5'd0, 9'd0}, 1'b1, OUT_OF_TABLE},
      '{'{11'd2047, 4'd15, 5'd31, 9'd511}, 1'b1, OUT_OF_TABLE},
      // before the first lunar new year in the tables: no record, solar term still given
      '{'{11'd2023, 4'd0, 5'd1, 9'd0}, 1'b1, OUT_OF_TABLE},
      '{'{11'd2023, 4'd0, 5'd5, 9'd4}, 1'b1, '{4'd0, 5'd0, 1'b0, 5'd0, 1'b1}},
      '{'{11'd2023, 4'd0, 5'd20, 9'd19}, 1'b1, '{4'd0, 5'd0, 1'b0, 5'd1, 1'b1}},
      '{'{11'd2024, 4'd1, 5'd10, 9'd40}, 1'b1, '{4'd0, 5'd0, 1'b0, NO_TERM, 1'b0}},
      '{'{11'd2023, 4'd0, 5'd22, 9'd21}, 1'b0, PREDICTED},
      '{'{11'd2024, 4'd0, 5'd10, 9'd9}, 1'b0, PREDICTED},
      '{'{11'd2025, 4'd0, 5'd10, 9'd9}, 1'b0, PREDICTED},
      '{'{11'd2025, 4'd7, 5'd5, 9'd216}, 1'b0, PREDICTED},
      '{'{11'd2023, 4'd3, 5'd20, 9'd109}, 1'b0, PREDICTED},
      '{'{11'd2034, 4'd11, 5'd31, 9'd364}, 1'b0, PREDICTED},
      '{'{11'd2028, 4'd11, 5'd31, 9'd365}, 1'b0, PREDICTED},
      '{'{11'd2034, 4'd15, 5'd0, 9'd511}, 1'b0, PREDICTED},
      '{'{11'd2030, 4'd12, 5'd16, 9'd400}, 1'b0, PREDICTED},
      '{'{11'd2026, 4'd5, 5'd21, 9'd171}, 1'b0, PREDICTED},
      '{'{11'd2031, 4'd9, 5'd8, 9'd280}, 1'b0, PREDICTED},
      '{'{11'd2029, 4'd0, 5'd31, 9'd365}, 1'b0, PREDICTED},
      '{'{11'd2027, 4'd2, 5'd0, 9'd0}, 1'b0, PREDICTED}
   };

   logic    clock;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   rsp_type expected_dates [$];
   int      dates_sent = 0;
   int      burst_left = 1;
   int      mismatches = 0;
   int      lunar_results = 0;
   int      range_errors = 0;
   int      term_days = 0;
   int      leap_days = 0;

   solar_to_lunar_date #(
      .FIRST_YEAR (FIRST_YEAR),
      .NUM_YEARS  (NUM_YEARS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic rsp_type lunar_of(input req_type r);
      rsp_type    res;
      logic [23:0] rec;
      int         yi, mi, half, base, tbit, target;
      int         prev_year, days, mdays, mon, intercal_no;
      logic       leap;
      res = OUT_OF_TABLE;
      yi = int'(r.greg_year) - FIRST_YEAR;
      if (yi < 0 || yi >= NUM_YEARS)
         return res;

      mi = int'(r.month_index);
      if (mi <= int'(MONTH_LAST)) begin
         half = (r.day_in_month > HALF_SPLIT) ? 1 : 0;
         base = int'(SOLAR_BASE[mi]);
         tbit = (int'(SOLAR_MASK[yi * 3 + mi / 4]) >> ((mi % 4) * 2 + half)) & 1;
         target = tbit + (half ? (base >> 4) + 15 : base & 15);
         if (int'(r.day_in_month) == target)
            res.solar_term = 5'(mi * 2 + half);
      end

      rec = LUNAR_YEAR[yi];
      days = int'(r.day_in_year);
      // before this year's lunar new year: count from last year's record
      if (int'(rec[5:0]) > days) begin
         if (yi == 0)
            return res;
         rec = LUNAR_YEAR[yi - 1];
         prev_year = int'(r.greg_year) - 1;
         days += int'(YEAR_DAYS);
         if ((prev_year % 4 == 0 && prev_year % 100 != 0) || prev_year % 400 == 0)
            days += 1;
      end
      days -= int'(rec[5:0]) - 1;

      mon = 0;
      mdays = rec[10] ? int'(DAYS_LONG) : int'(DAYS_SHORT);
      while (days > mdays) begin
         days -= mdays;
         mon++;
         if (mon > 12)
            return res;
         mdays = rec[mon + 10] ? int'(DAYS_LONG) : int'(DAYS_SHORT);
      end

      leap = 1'b0;
      intercal_no = int'(rec[9:6]);
      if (intercal_no != 0) begin
         if (intercal_no == mon)
            leap = 1'b1;
         if (intercal_no <= mon)
            mon--;
      end
      if (mon > int'(MONTH_LAST))
         return res;

      res.lunar_month = 4'(mon);
      res.lunar_day = 5'(days - 1);
      res.is_leap_month = leap;
      res.out_of_range = 1'b0;
      return res;
   endfunction

   function automatic req_type random_date();
      req_type r;
      int      sel;
      sel = $urandom_range(0, 19);
      r.greg_year = 11'($urandom_range(FIRST_YEAR, FIRST_YEAR + NUM_YEARS - 1));
      r.month_index = 4'($urandom_range(0, 11));
      r.day_in_month = 5'($urandom_range(1, 31));
      r.day_in_year = 9'($urandom_range(0, 365));
      if (sel < 5) begin
         // land near the solar term days of both month halves
         r.day_in_month = $urandom_range(0, 1) ? 5'($urandom_range(3, 9))
                                               : 5'($urandom_range(17, 24));
      end else if (sel < 7) begin
         r.day_in_year = 9'($urandom_range(0, 62));
      end else if (sel == 7) begin
         r.greg_year = $urandom_range(0, 1) ? 11'(FIRST_YEAR - 1) : 11'(FIRST_YEAR + NUM_YEARS);
      end else if (sel == 8) begin
         r = 29'($urandom);
      end else if (sel == 9) begin
         r.month_index = 4'($urandom_range(12, 15));
         r.day_in_year = 9'($urandom_range(366, 511));
      end
      return r;
   endfunction

   // Drive one transaction, wait for accept, then pace the sender in bursts.
   task automatic issue(input req_type r, input logic known, input rsp_type rsp);
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      expected_dates.push_back(known ? rsp : lunar_of(r));
      dates_sent++;
      burst_left--;
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 24)) @(posedge clock);
         burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(10, 30) : $urandom_range(1, 6);
      end
   endtask

   function automatic void check_field(input string field, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_dates.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response with no transaction outstanding", $time);
         end else begin
            want = expected_dates.pop_front();
            check_field("lunar_month", 8'(want.lunar_month), 8'(rsp_data.lunar_month));
            check_field("lunar_day", 8'(want.lunar_day), 8'(rsp_data.lunar_day));
            check_field("is_leap_month", 8'(want.is_leap_month), 8'(rsp_data.is_leap_month));
            check_field("solar_term", 8'(want.solar_term), 8'(rsp_data.solar_term));
            check_field("out_of_range", 8'(want.out_of_range), 8'(rsp_data.out_of_range));
            if (want.out_of_range)
               range_errors++;
            else
               lunar_results++;
            if (want.solar_term != NO_TERM)
               term_days++;
            if (want.is_leap_month)
               leap_days++;
         end
      end
   end

   // Abort when no transaction is accepted for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (start && !busy)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Timed out after %0d idle cycles", IDLE_LIMIT);
      $display("FAILURE");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < $size(DIRECTED); i++)
         issue(DIRECTED[i].req, DIRECTED[i].known, DIRECTED[i].rsp);
      for (int i = 0; i < RANDOM_DATES; i++)
         issue(random_date(), 1'b0, PREDICTED);
      start <= 1'b0;

      while (expected_dates.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Converted %0d dates: %0d lunar dates, %0d out of range, %0d solar term days,",
               dates_sent, lunar_results, range_errors, term_days);
      $display("%0d dates in a leap month, %0d mismatches", leap_days, mismatches);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
